/* design/grid_linear_interpolator_core_assert.svh */
// Assertion macros for the grid interpolator core.
// Expects signals named clock and reset in the module that expands them.
`ifndef GRID_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define GRID_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH

// same-cycle implication
`define GLI_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GLI_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/gli_pkg.sv */
// Shared types and constants for the grid interpolator core.
// No dependencies; imported by gli_divider, grid_linear_interpolator_core and the testbench.
package gli_pkg;

   localparam logic [1:0] KIND_LOAD_POS    = 2'd0;
   localparam logic [1:0] KIND_LOAD_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_QUERY       = 2'd2;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned DIVISOR_W  = 32;
   localparam int unsigned DIVIDEND_W = 65;
   localparam int unsigned QUOT_W     = 35;

   localparam logic signed [DATA_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] RES_MIN = 32'sh8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_FIRST,
      ST_RD_LAST,
      ST_CHK_LAST,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_FT_LO,
      ST_FT_HI,
      ST_FT_CAP,
      ST_DIFF,
      ST_MUL,
      ST_PREP,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_ADD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              done;
      logic              ovf;
      logic [QUOT_W-1:0] quot;
   } div_out_type;

   // v mod m for a 6-bit v, by shifted compare-subtract
   function automatic logic [5:0] reduce_mod(input logic [5:0] v, input int unsigned m);
      logic [18:0] acc;
      logic [18:0] sub;
      acc = 19'(v);
      for (int k = 5; k >= 0; k--) begin
         sub = 19'(m) << k;
         if (acc >= sub) acc = acc - sub;
      end
      return acc[5:0];
   endfunction

endpackage

/* design/gli_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// Standalone; used for the grid positions and the sample store.
module gli_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/gli_divider.sv */
// Serial restoring divider, one quotient bit per cycle.
// Depends on gli_pkg for widths and the result struct.
module gli_divider
   import gli_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output div_out_type           div_out
);

   localparam int unsigned CNT_W = $clog2(QUOT_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] divisor_ff;
   logic [QUOT_W-1:0]    quot_ff;
   logic                 ovf_ff;
   logic [DIVISOR_W:0]   trial;
   logic                 ge;
   logic                 top_ovf;

   // quotient would need more than QUOT_W bits
   assign top_ovf = DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]) >= divisor;

   assign trial = {rem_ff, quot_ff[QUOT_W-1]};
   assign ge    = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = !top_ovf;
         done_in = top_ovf;
      end else if (busy_ff && cnt_ff == '0) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         if (start) begin
            cnt_ff <= CNT_W'(QUOT_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         divisor_ff <= divisor;
         rem_ff     <= DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
         quot_ff    <= dividend[QUOT_W-1:0];
         ovf_ff     <= top_ovf;
      end else if (busy_ff) begin
         rem_ff  <= ge ? DIVISOR_W'(trial - {1'b0, divisor_ff}) : trial[DIVISOR_W-1:0];
         quot_ff <= {quot_ff[QUOT_W-2:0], ge};
      end
   end

   assign div_out.done = done_ff;
   assign div_out.ovf  = ovf_ff;
   assign div_out.quot = quot_ff;

endmodule

/* design/grid_linear_interpolator_core.sv */
// Channel  Dir  Handshake            Word
// req      in   req_valid/req_stall  kind, row, index, position, value
// rsp      out  rsp_valid/rsp_stall  result, below_range, degenerate_segment, saturated
// csr      in   csr_wr_en            num_points (7 bits)
//
// A query below the first position skips to the output; a zero-width segment skips
// the multiply and the serial divider, and a quotient overflow the divider's bit loop.
// Bisection takes at most ceil(log2(n-1)) steps, none at or past the last position.
// Reset is synchronous: control state and num_points (back to 2) only; the memories
// are not cleared. A finished word sits in the output register while the next word is
// taken; a query that finishes while that register is still full waits.
//
// Piecewise linear interpolator over a grid held in two synchronous RAMs.
// Depends on gli_pkg, gli_ram, gli_divider and the assertion macro header.
`include "grid_linear_interpolator_core_assert.svh"

module grid_linear_interpolator_core
   import gli_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 64,
   parameter int unsigned MAX_ROWS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [6:0]         csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [3:0]         req_row,
   input  logic [5:0]         req_index,
   input  logic signed [31:0] req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result,
   output logic               rsp_below_range,
   output logic               rsp_degenerate_segment,
   output logic               rsp_saturated
);

   localparam int unsigned PW = $clog2(MAX_POINTS);
   localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int unsigned SW = $clog2(MAX_ROWS * MAX_POINTS);

   state_type state_ff, state_in;

   logic [6:0]               num_points_ff;
   logic [PW-1:0]            n_m1_ff, lo_ff, hi_ff;
   logic [SW-1:0]            base_ff;
   logic signed [DATA_W-1:0] q_ff, x0_ff, x1_ff, y0_ff, y1_ff;
   logic [DATA_W-1:0]        adx_ff, ady_ff, adq_ff;
   logic                     neg_ff;
   logic [2*DATA_W-1:0]      prod_ff;
   logic [DIVIDEND_W-1:0]    dividend_ff;
   logic signed [DATA_W-1:0] res_ff;
   logic                     below_ff, degen_ff, sat_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_result_ff;
   logic                     rsp_below_ff, rsp_degen_ff, rsp_sat_ff;

   logic              req_accept;
   logic [PW-1:0]     idx_red;
   logic [RW-1:0]     row_red;
   logic [SW-1:0]     row_base;
   logic [12:0]       n_use;
   logic [PW-1:0]     n_m1;

   logic              grid_wr_en, samp_wr_en;
   logic [PW-1:0]     grid_rd_addr;
   logic [SW-1:0]     samp_rd_addr;
   logic [DATA_W-1:0] grid_rd_data, samp_rd_data;
   logic signed [DATA_W-1:0] grid_val;

   logic [PW:0]       mid_sum;
   logic [PW-1:0]     mid, lo_n, hi_n;
   logic              grid_le, more, below, past;

   logic signed [DATA_W:0] dx_s, dy_s, dq_s;
   logic              dx_zero;

   logic              div_start;
   div_out_type       div_out;
   logic              q_big;
   logic signed [QUOT_W+1:0] t_s, sum_s;

   logic              out_load;

   // ---------------- input side ----------------
   assign req_accept = req_valid && !req_stall;
   assign idx_red    = PW'(reduce_mod(req_index, MAX_POINTS));
   assign row_red    = RW'(reduce_mod({2'b00, req_row}, MAX_ROWS));
   assign row_base   = SW'(row_red) * SW'(MAX_POINTS);

   always_comb begin
      n_use = 13'(num_points_ff);
      if (n_use < 13'd2) n_use = 13'd2;
      if (n_use > 13'(MAX_POINTS)) n_use = 13'(MAX_POINTS);
      n_m1 = PW'(n_use - 13'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff <= 7'd2;
      end else if (csr_wr_en) begin
         num_points_ff <= csr_wr_data;
      end
   end

   // ---------------- memories ----------------
   gli_ram #(.DEPTH(MAX_POINTS), .WIDTH(DATA_W)) u_grid_ram (
      .clock   (clock),
      .wr_en   (grid_wr_en),
      .wr_addr (idx_red),
      .wr_data (req_position),
      .rd_addr (grid_rd_addr),
      .rd_data (grid_rd_data)
   );

   gli_ram #(.DEPTH(MAX_ROWS * MAX_POINTS), .WIDTH(DATA_W)) u_samp_ram (
      .clock   (clock),
      .wr_en   (samp_wr_en),
      .wr_addr (row_base + SW'(idx_red)),
      .wr_data (req_value),
      .rd_addr (samp_rd_addr),
      .rd_data (samp_rd_data)
   );

   assign grid_val = $signed(grid_rd_data);

   // ---------------- search and segment math ----------------
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[PW:1];
   assign grid_le = grid_val <= q_ff;
   assign lo_n    = grid_le ? mid : lo_ff;
   assign hi_n    = grid_le ? hi_ff : mid;
   assign more    = (hi_n - lo_n) > PW'(1);
   assign below   = q_ff < grid_val;
   assign past    = q_ff >= grid_val;

   assign dx_s    = {x1_ff[DATA_W-1], x1_ff} - {x0_ff[DATA_W-1], x0_ff};
   assign dy_s    = {y1_ff[DATA_W-1], y1_ff} - {y0_ff[DATA_W-1], y0_ff};
   assign dq_s    = {q_ff[DATA_W-1], q_ff} - {x0_ff[DATA_W-1], x0_ff};
   assign dx_zero = dx_s == '0;

   gli_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_ff),
      .divisor  (adx_ff),
      .div_out  (div_out)
   );

   // quotient above 2^34 always saturates
   assign q_big = div_out.ovf || (div_out.quot[QUOT_W-1] && |div_out.quot[QUOT_W-2:0]);
   assign t_s   = neg_ff ? -$signed({2'b00, div_out.quot}) : $signed({2'b00, div_out.quot});
   assign sum_s = (QUOT_W + 2)'(y0_ff) + t_s;

   // ---------------- control ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_accept && req_kind == KIND_QUERY) state_in = ST_RD_FIRST;
         ST_RD_FIRST: state_in = ST_RD_LAST;
         ST_RD_LAST:  state_in = below ? ST_OUT : ST_CHK_LAST;
         ST_CHK_LAST: begin
            if (past || n_m1_ff <= PW'(1)) state_in = ST_FT_LO;
            else state_in = ST_SRCH_RD;
         end
         ST_SRCH_RD:  state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: state_in = more ? ST_SRCH_RD : ST_FT_LO;
         ST_FT_LO:    state_in = ST_FT_HI;
         ST_FT_HI:    state_in = ST_FT_CAP;
         ST_FT_CAP:   state_in = ST_DIFF;
         ST_DIFF:     state_in = dx_zero ? ST_OUT : ST_MUL;
         ST_MUL:      state_in = ST_PREP;
         ST_PREP:     state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_out.done) state_in = ST_ADD;
         ST_ADD:      state_in = ST_OUT;
         ST_OUT:      if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = state_ff != ST_IDLE;
      grid_wr_en   = req_accept && req_kind == KIND_LOAD_POS;
      samp_wr_en   = req_accept && req_kind == KIND_LOAD_SAMPLE;
      div_start    = state_ff == ST_DIV_GO;
      out_load     = state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall);
      grid_rd_addr = '0;
      samp_rd_addr = base_ff + SW'(lo_ff);
      unique case (state_ff)
         ST_RD_LAST: grid_rd_addr = n_m1_ff;
         ST_SRCH_RD: grid_rd_addr = mid;
         ST_FT_LO:   grid_rd_addr = lo_ff;
         ST_FT_HI: begin
            grid_rd_addr = lo_ff + PW'(1);
            samp_rd_addr = base_ff + SW'(lo_ff) + SW'(1);
         end
         default:    grid_rd_addr = '0;
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            q_ff     <= req_position;
            base_ff  <= row_base;
            n_m1_ff  <= n_m1;
            res_ff   <= '0;
            below_ff <= 1'b0;
            degen_ff <= 1'b0;
            sat_ff   <= 1'b0;
         end
         ST_RD_LAST: below_ff <= below;
         ST_CHK_LAST: begin
            // at or past the last point: extrapolate on the final segment
            lo_ff <= past ? n_m1_ff - PW'(1) : '0;
            hi_ff <= n_m1_ff;
         end
         ST_SRCH_CMP: begin
            lo_ff <= lo_n;
            hi_ff <= hi_n;
         end
         ST_FT_HI: begin
            x0_ff <= grid_val;
            y0_ff <= $signed(samp_rd_data);
         end
         ST_FT_CAP: begin
            x1_ff <= grid_val;
            y1_ff <= $signed(samp_rd_data);
         end
         ST_DIFF: begin
            degen_ff <= dx_zero;
            adx_ff   <= dx_s[DATA_W] ? DATA_W'(-dx_s) : dx_s[DATA_W-1:0];
            ady_ff   <= dy_s[DATA_W] ? DATA_W'(-dy_s) : dy_s[DATA_W-1:0];
            adq_ff   <= dq_s[DATA_W] ? DATA_W'(-dq_s) : dq_s[DATA_W-1:0];
            neg_ff   <= dx_s[DATA_W] ^ dy_s[DATA_W] ^ dq_s[DATA_W];
         end
         ST_MUL: prod_ff <= ady_ff * adq_ff;
         // add half the divisor so the quotient rounds to nearest
         ST_PREP: dividend_ff <= DIVIDEND_W'(prod_ff) + DIVIDEND_W'(adx_ff[DATA_W-1:1]);
         ST_ADD: begin
            if (q_big) begin
               sat_ff <= 1'b1;
               res_ff <= neg_ff ? RES_MIN : RES_MAX;
            end else if (sum_s > (QUOT_W + 2)'(RES_MAX)) begin
               sat_ff <= 1'b1;
               res_ff <= RES_MAX;
            end else if (sum_s < (QUOT_W + 2)'(RES_MIN)) begin
               sat_ff <= 1'b1;
               res_ff <= RES_MIN;
            end else begin
               res_ff <= sum_s[DATA_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_result_ff <= res_ff;
         rsp_below_ff  <= below_ff;
         rsp_degen_ff  <= degen_ff;
         rsp_sat_ff    <= sat_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result             = rsp_result_ff;
   assign rsp_below_range        = rsp_below_ff;
   assign rsp_degenerate_segment = rsp_degen_ff;
   assign rsp_saturated          = rsp_sat_ff;

   // ---------------- assertions ----------------
   `GLI_ASSERT_IMP(a_flag_zero_word,
      rsp_valid && (rsp_below_range || rsp_degenerate_segment),
      rsp_result == '0 && !rsp_saturated && !(rsp_below_range && rsp_degenerate_segment),
      "below or degenerate word must be zero with one flag")
   `GLI_ASSERT_IMP(a_div_done_in_wait, div_out.done, state_ff == ST_DIV_WAIT,
      "divider finished outside its wait state")
   `GLI_ASSERT_NXT(a_query_blocks_input,
      req_valid && !req_stall && req_kind == KIND_QUERY, req_stall,
      "input not stalled after a query word")
   `GLI_ASSERT_IMP(a_search_window, state_ff == ST_SRCH_RD,
      hi_ff > lo_ff && hi_ff <= n_m1_ff, "bisection window out of range")

endmodule

/* tb/tb_grid_linear_interpolator_core.sv */
// Self-checking testbench for grid_linear_interpolator_core: directed and random words
// with random idling on both channels. Depends on gli_pkg and the core RTL only.
module tb_grid_linear_interpolator_core;
   timeunit 1ns;
   timeprecision 1ps;
   import gli_pkg::*;

   localparam logic [1:0]         KIND_UNUSED  = 2'd3;
   localparam int unsigned        GRID_DEPTH   = 64;
   localparam int unsigned        ROW_COUNT    = 16;
   localparam int unsigned        WORD_TARGET  = 1700;
   localparam int unsigned        SETTLE_TICKS = 120;
   localparam logic signed [31:0] Q_ONE        = 32'sh0001_0000;
   localparam logic signed [31:0] Q_HALF       = 32'sh0000_8000;

   typedef struct packed {
      logic signed [31:0] result;
      logic               below_range;
      logic               degenerate_segment;
      logic               saturated;
   } answer_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [6:0]         csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind = '0;
   logic [3:0]         req_row = '0;
   logic [5:0]         req_index = '0;
   logic signed [31:0] req_position = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_result;
   logic               rsp_below_range;
   logic               rsp_degenerate_segment;
   logic               rsp_saturated;

   // shadow copy of the block's state
   logic [6:0]         point_cfg = 7'd2;
   logic signed [31:0] grid_pos [GRID_DEPTH];
   logic signed [31:0] samples [ROW_COUNT][GRID_DEPTH];
   bit                 grid_set [GRID_DEPTH];

   answer_type  pending_answers[$];
   int unsigned fault_count = 0;
   int unsigned sent_words = 0;
   int unsigned stall_left = 0;
   bit          req_steady = 1'b0;
   bit          rsp_steady = 1'b0;

   grid_linear_interpolator_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_kind               (req_kind),
      .req_row                (req_row),
      .req_index              (req_index),
      .req_position           (req_position),
      .req_value              (req_value),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_result             (rsp_result),
      .rsp_below_range        (rsp_below_range),
      .rsp_degenerate_segment (rsp_degenerate_segment),
      .rsp_saturated          (rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned points_in_force();
      if (point_cfg < 7'd2) return 2;
      if (point_cfg > 7'(GRID_DEPTH)) return GRID_DEPTH;
      return point_cfg;
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic signed [31:0] clip32(longint v);
      if (v > longint'(RES_MAX)) return RES_MAX;
      if (v < longint'(RES_MIN)) return RES_MIN;
      return v[31:0];
   endfunction

   // mostly short, a few long
   function automatic int unsigned pick_idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // piecewise-linear answer for one query against the shadow state
   function automatic answer_type interpolate_at(int unsigned r, logic signed [31:0] q);
      answer_type  a;
      int unsigned n, lo, hi, mid, seg;
      longint      x0, x1, y0, y1, dx, dy, dq, res, t;
      logic [65:0] adx, prod, quo;
      bit          neg;
      a = '0;
      n = points_in_force();
      if (q < grid_pos[0]) begin
         a.below_range = 1'b1;
         return a;
      end
      if (q >= grid_pos[n-1]) begin
         seg = n - 2;
      end else begin
         lo = 0;
         hi = n - 1;
         while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (grid_pos[mid] <= q) lo = mid;
            else hi = mid;
         end
         seg = lo;
      end
      x0 = grid_pos[seg];
      x1 = grid_pos[seg+1];
      y0 = samples[r][seg];
      y1 = samples[r][seg+1];
      dx = x1 - x0;
      if (dx == 0) begin
         a.degenerate_segment = 1'b1;
         return a;
      end
      dy = y1 - y0;
      dq = longint'(q) - x0;
      adx = 66'(magnitude(dx));
      prod = 66'(magnitude(dy)) * 66'(magnitude(dq));
      // round half away from zero on the magnitude
      quo = (prod + adx / 2) / adx;
      neg = ((dy < 0) != (dq < 0)) != (dx < 0);
      if (quo > 66'h4_0000_0000) begin
         a.saturated = 1'b1;
         a.result = neg ? RES_MIN : RES_MAX;
      end else begin
         t = neg ? -longint'(quo) : longint'(quo);
         res = y0 + t;
         a.result = clip32(res);
         a.saturated = (res > longint'(RES_MAX)) || (res < longint'(RES_MIN));
      end
      return a;
   endfunction

   // valid stays high after acceptance until the next call or a drain lowers it
   task automatic send_word(input logic [1:0] kind, input logic [3:0] row,
                            input logic [5:0] idx, input logic signed [31:0] pos,
                            input logic signed [31:0] val);
      int unsigned gap;
      gap = (req_steady || $urandom_range(0, 99) < 45) ? 0 : pick_idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_row      <= row;
      req_index    <= idx;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (req_stall);
      case (kind)
         KIND_LOAD_POS: begin
            grid_pos[idx] = pos;
            grid_set[idx] = 1'b1;
         end
         KIND_LOAD_SAMPLE: samples[row][idx] = val;
         KIND_QUERY: pending_answers.push_back(interpolate_at(row, pos));
         default: ;
      endcase
      if (kind != KIND_UNUSED) sent_words++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      // loads leave no answer behind, so give the block time to go idle
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_point_count(input logic [6:0] v);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      point_cfg = v;
   endtask

   task automatic test_basic_segment();
      send_word(KIND_LOAD_POS, 4'd0, 6'd0, 32'sd0, 32'sd0);
      send_word(KIND_LOAD_POS, 4'd0, 6'd1, Q_ONE, 32'sd0);
      send_word(KIND_LOAD_SAMPLE, 4'd0, 6'd0, 32'sd0, 32'sd0);
      send_word(KIND_LOAD_SAMPLE, 4'd0, 6'd1, 32'sd0, Q_ONE * 10);
      send_word(KIND_QUERY, 4'd0, 6'd0, 32'sd0, 32'sd0);
      send_word(KIND_QUERY, 4'd0, 6'd0, Q_HALF + 32'sd1, 32'sd0);
      send_word(KIND_QUERY, 4'd0, 6'd0, Q_ONE, 32'sd0);
      send_word(KIND_QUERY, 4'd0, 6'd0, Q_ONE * 3, 32'sd0);
      send_word(KIND_QUERY, 4'd0, 6'd0, RES_MAX, 32'sd0);
   endtask

   task automatic test_value_extremes();
      send_word(KIND_LOAD_SAMPLE, 4'd15, 6'd0, 32'sd0, RES_MAX);
      send_word(KIND_LOAD_SAMPLE, 4'd15, 6'd1, 32'sd0, RES_MIN);
      send_word(KIND_QUERY, 4'd15, 6'd0, Q_HALF, 32'sd0);
      send_word(KIND_QUERY, 4'd15, 6'd0, RES_MAX, 32'sd0);
      send_word(KIND_QUERY, 4'd15, 6'd0, RES_MIN, 32'sd0);
   endtask

   task automatic test_unused_kind();
      send_word(KIND_UNUSED, 4'hF, 6'h3F, $urandom, $urandom);
      send_word(KIND_UNUSED, 4'd0, 6'd0, $urandom, $urandom);
      send_word(KIND_QUERY, 4'd0, 6'd0, Q_HALF, 32'sd0);
   endtask

   // equal end positions flag the segment; a query below the grid still wins
   task automatic test_degenerate_segment();
      send_word(KIND_LOAD_POS, 4'd0, 6'd1, 32'sd0, 32'sd0);
      send_word(KIND_QUERY, 4'd0, 6'd0, 32'sd0, 32'sd0);
      send_word(KIND_QUERY, 4'd0, 6'd0, -32'sd1, 32'sd0);
      send_word(KIND_LOAD_POS, 4'd0, 6'd1, Q_ONE, 32'sd0);
   endtask

   task automatic test_top_index();
      send_word(KIND_LOAD_POS, 4'd0, 6'h3F, RES_MAX, RES_MIN);
      send_word(KIND_LOAD_SAMPLE, 4'hF, 6'h3F, RES_MIN, RES_MIN);
   endtask

   // counts below two behave as two
   task automatic test_point_count_limits();
      write_point_count(7'd0);
      send_word(KIND_QUERY, 4'd0, 6'd0, Q_HALF, 32'sd0);
      write_point_count(7'd1);
      send_word(KIND_QUERY, 4'd15, 6'd0, Q_HALF - 32'sd1, 32'sd0);
   endtask

   function automatic logic [6:0] pick_point_count();
      case ($urandom_range(0, 19))
         0: return 7'd0;
         1: return 7'd1;
         2: return 7'd2;
         3: return 7'(GRID_DEPTH);
         4: return 7'($urandom_range(65, 126));
         5: return 7'd127;
         6, 7, 8, 9, 10, 11, 12: return 7'($urandom_range(2, 6));
         13, 14, 15, 16: return 7'($urandom_range(7, 20));
         default: return 7'($urandom_range(21, 63));
      endcase
   endfunction

   function automatic logic signed [31:0] pick_query_pos(int unsigned n);
      longint      lo, hi;
      int unsigned i;
      case ($urandom_range(0, 9))
         0: return clip32(longint'(grid_pos[0]) - longint'($urandom_range(1, 1000)));
         1, 2: return grid_pos[$urandom_range(0, n - 1)];
         3, 4, 5: begin
            i = $urandom_range(0, n - 2);
            lo = grid_pos[i];
            hi = grid_pos[i+1];
            if (hi > lo) return clip32(lo + longint'($urandom) % (hi - lo));
            return grid_pos[i];
         end
         6: return clip32(longint'(grid_pos[n-1]) + longint'($urandom_range(0, 1 << 20)));
         7: return $urandom_range(0, 1) ? RES_MAX : RES_MIN;
         default: return $urandom;
      endcase
   endfunction

   task automatic load_grid(input int unsigned n, input int unsigned shift, input bit partial);
      int          pts[$];
      int          v;
      int unsigned shape, i;
      pts = {};
      shape = $urandom_range(0, 9);
      for (i = 0; i < n; i++) begin
         v = $urandom;
         pts.push_back(v >>> shift);
      end
      if ($urandom_range(0, 7) == 0) pts[0] = RES_MIN;
      if ($urandom_range(0, 7) == 0) pts[n-1] = RES_MAX;
      if (shape < 9) pts.sort();
      if (shape >= 7 && shape < 9) begin
         for (i = 1; i < n; i++)
            if ($urandom_range(0, 3) == 0) pts[i] = pts[i-1];
      end
      for (i = 0; i < n; i++)
         if (!grid_set[i] || !partial || $urandom_range(0, 1))
            send_word(KIND_LOAD_POS, 4'($urandom), 6'(i), pts[i], $urandom);
   endtask

   task automatic load_row(input int unsigned r, input int unsigned n,
                           input int unsigned shift);
      int          v;
      int unsigned i;
      for (i = 0; i < n; i++) begin
         v = $urandom;
         send_word(KIND_LOAD_SAMPLE, 4'(r), 6'(i), $urandom, v >>> shift);
      end
   endtask

   // random phases: count, grid, a few rows, then a query stream with noise
   task automatic test_random_sweeps();
      int unsigned n, r, shift_pos, shift_val;
      int unsigned live_rows[$];
      bit          partial;
      while (sent_words < WORD_TARGET) begin
         write_point_count(pick_point_count());
         n = points_in_force();
         req_steady = ($urandom_range(0, 4) == 0);
         rsp_steady = ($urandom_range(0, 4) == 0);
         shift_pos = $urandom_range(0, 24);
         shift_val = $urandom_range(0, 31);
         partial = ($urandom_range(0, 5) == 0);
         load_grid(n, shift_pos, partial);
         live_rows = {};
         repeat ($urandom_range(1, 3)) begin
            r = $urandom_range(0, ROW_COUNT - 1);
            load_row(r, n, shift_val);
            live_rows.push_back(r);
         end
         repeat ($urandom_range(15, 50)) begin
            case ($urandom_range(0, 19))
               0: send_word(KIND_UNUSED, 4'($urandom), 6'($urandom), $urandom, $urandom);
               1: send_word(KIND_LOAD_SAMPLE, 4'($urandom), 6'($urandom), $urandom, $urandom);
               2: send_word(KIND_LOAD_POS, 4'($urandom), 6'($urandom), $urandom, $urandom);
               default: ;
            endcase
            r = live_rows[$urandom_range(0, live_rows.size() - 1)];
            send_word(KIND_QUERY, 4'(r), 6'($urandom), pick_query_pos(n), $urandom);
         end
      end
   endtask

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         fault_count++;
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : answer_check
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            fault_count++;
            $display("%0t: unexpected result word: expected none, got result %0d",
                     $time, rsp_result);
         end else begin
            want = pending_answers.pop_front();
            compare_field("result", want.result, rsp_result);
            compare_field("below_range", want.below_range, rsp_below_range);
            compare_field("degenerate_segment", want.degenerate_segment,
                          rsp_degenerate_segment);
            compare_field("saturated", want.saturated, rsp_saturated);
         end
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!rsp_steady && $urandom_range(0, 99) < 25) begin
         rsp_stall <= 1'b1;
         stall_left = pick_idle_len() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_basic_segment();
      test_value_extremes();
      test_unused_kind();
      test_degenerate_segment();
      test_top_index();
      test_point_count_limits();
      test_random_sweeps();
      drain_results();
      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #25ms;
      $display("timeout with %0d results outstanding", pending_answers.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
